@@ hdl/delimited_field_splitter_assert.svh @@
// assertion macros for the delimited field splitter
`ifndef DELIMITED_FIELD_SPLITTER_ASSERT_SVH
`define DELIMITED_FIELD_SPLITTER_ASSERT_SVH
`ifndef SYNTHESIS
`define DFS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: property failed");
`define DFS_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("%m: forbidden condition seen");
`else
`define DFS_ASSERT(label, prop)
`define DFS_ASSERT_NEVER(label, expr)
`endif
`endif

@@ hdl/dfs_pkg.sv @@
// shared constants and register codes for the delimited field splitter
package dfs_pkg;

  localparam int DEF_MAX_SEPARATOR = 8;
  localparam int DEF_OFFSET_BITS   = 16;
  localparam int DEF_MAX_FIELDS    = 256;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 64;
  localparam int SEP_LEN_BITS   = 4;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_SEPARATOR_BYTES  = 2'd0,
    REG_SEPARATOR_LENGTH = 2'd1,
    REG_TRIM_SPACES      = 2'd2
  } cfg_reg_t;

  localparam logic [CFG_DATA_BITS-1:0] RESET_SEPARATOR_BYTES  = 64'd44;
  localparam logic [SEP_LEN_BITS-1:0]  RESET_SEPARATOR_LENGTH = 4'd1;

  localparam logic [7:0] SPACE_CHAR = 8'h20;

  localparam int QUEUE_DEPTH      = 4;
  localparam int QUEUE_PTR_BITS   = 2;
  localparam int QUEUE_COUNT_BITS = 3;

endpackage

@@ hdl/dfs_front.sv @@
// front end: config registers, separator match, trim tracking, field records
`include "delimited_field_splitter_assert.svh"
module dfs_front #(
  parameter int MAX_SEPARATOR = dfs_pkg::DEF_MAX_SEPARATOR,
  parameter int OFFSET_BITS   = dfs_pkg::DEF_OFFSET_BITS,
  parameter int MAX_FIELDS    = dfs_pkg::DEF_MAX_FIELDS,
  localparam int FNUM_BITS    = $clog2(MAX_FIELDS),
  localparam int REC_BITS     = 3 + 2 * (3 * OFFSET_BITS + FNUM_BITS)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                write_enable,
  input  logic [dfs_pkg::CFG_INDEX_BITS-1:0]  register_index,
  input  logic [dfs_pkg::CFG_DATA_BITS-1:0]   write_data,
  input  logic                                byte_valid,
  output logic                                byte_stall,
  input  logic [7:0]                          data_byte,
  input  logic                                line_end,
  input  logic                                queue_full,
  output logic                                push,
  output logic [REC_BITS-1:0]                 rec
);
  import dfs_pkg::*;

  localparam int LEN_BITS     = $clog2(MAX_SEPARATOR + 1);
  localparam int WIN_IDX_BITS = (MAX_SEPARATOR > 1) ? $clog2(MAX_SEPARATOR) : 1;
  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;
  localparam logic [FNUM_BITS-1:0]   NUMBER_MAX = FNUM_BITS'(MAX_FIELDS - 1);

  typedef struct packed {
    logic [OFFSET_BITS-1:0] start;
    logic [OFFSET_BITS-1:0] stop;
    logic [OFFSET_BITS-1:0] ns_end;
    logic [FNUM_BITS-1:0]   number;
  } dfs_res_t;

  typedef struct packed {
    logic     sep_valid;
    dfs_res_t sep;
    logic     end_valid;
    dfs_res_t fin;
    logic     trim;
  } dfs_rec_t;

  logic [CFG_DATA_BITS-1:0] separator_bytes;
  logic [SEP_LEN_BITS-1:0]  separator_length;
  logic                     trim_trailing_spaces;

  logic [OFFSET_BITS-1:0] pos;
  logic [OFFSET_BITS-1:0] cfs;
  logic [LEN_BITS-1:0]    fill;
  logic [FNUM_BITS-1:0]   field_counter;
  logic [OFFSET_BITS-1:0] hist [MAX_SEPARATOR];
  logic [7:0]             win [MAX_SEPARATOR];

  logic                     accept;
  logic [LEN_BITS-1:0]      used_len;
  logic [LEN_BITS-1:0]      last_tap;
  logic [OFFSET_BITS-1:0]   nxt;
  logic [OFFSET_BITS-1:0]   diff;
  logic [OFFSET_BITS-1:0]   len_ext;
  logic [OFFSET_BITS-1:0]   sep_end;
  logic [OFFSET_BITS-1:0]   prior_ns;
  logic [OFFSET_BITS-1:0]   hist0_next;
  logic [7:0]               win_next [MAX_SEPARATOR];
  logic [MAX_SEPARATOR-1:0] byte_ok;
  logic [LEN_BITS-1:0]      fill_next;
  logic                     match;
  logic [FNUM_BITS-1:0]     number_inc;
  dfs_rec_t                 rec_out;

  assign byte_stall = queue_full;
  assign accept     = byte_valid && !queue_full;
  assign push       = accept && (match || line_end);
  assign rec        = rec_out;

  always_comb begin
    if (separator_length == '0) begin
      used_len = LEN_BITS'(1);
    end else if (separator_length > SEP_LEN_BITS'(MAX_SEPARATOR)) begin
      used_len = LEN_BITS'(MAX_SEPARATOR);
    end else begin
      used_len = LEN_BITS'(separator_length);
    end
  end

  assign last_tap   = used_len - LEN_BITS'(1);
  assign nxt        = (pos == OFFSET_MAX) ? pos : pos + OFFSET_BITS'(1);
  assign diff       = nxt - cfs;
  assign len_ext    = OFFSET_BITS'(used_len);
  assign sep_end    = (diff >= len_ext) ? nxt - len_ext : cfs;
  assign prior_ns   = hist[last_tap[WIN_IDX_BITS-1:0]];
  assign hist0_next = (data_byte != SPACE_CHAR) ? nxt : hist[0];
  assign fill_next  = (fill < LEN_BITS'(MAX_SEPARATOR)) ? fill + LEN_BITS'(1) : fill;
  assign number_inc = (field_counter == NUMBER_MAX) ? field_counter
                                                    : field_counter + FNUM_BITS'(1);

  always_comb begin
    win_next[0] = data_byte;
    for (int i = 1; i < MAX_SEPARATOR; i++) begin
      win_next[i] = win[i-1];
    end
  end

  // window byte len-1-i lines up with separator byte i
  always_comb begin
    logic [LEN_BITS-1:0] tap;
    for (int i = 0; i < MAX_SEPARATOR; i++) begin
      tap = last_tap - LEN_BITS'(i);
      byte_ok[i] = (LEN_BITS'(i) >= used_len) ||
                   (win_next[tap[WIN_IDX_BITS-1:0]] == separator_bytes[8*i +: 8]);
    end
  end

  assign match = (fill_next >= used_len) && (&byte_ok);

  always_comb begin
    rec_out.sep_valid  = match;
    rec_out.sep.start  = cfs;
    rec_out.sep.stop   = sep_end;
    rec_out.sep.ns_end = prior_ns;
    rec_out.sep.number = field_counter;
    rec_out.end_valid  = line_end;
    rec_out.fin.start  = match ? nxt : cfs;
    rec_out.fin.stop   = nxt;
    rec_out.fin.ns_end = match ? nxt : hist0_next;
    rec_out.fin.number = match ? number_inc : field_counter;
    rec_out.trim       = trim_trailing_spaces;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      separator_bytes      <= RESET_SEPARATOR_BYTES;
      separator_length     <= RESET_SEPARATOR_LENGTH;
      trim_trailing_spaces <= 1'b0;
    end else if (write_enable) begin
      unique case (register_index)
        REG_SEPARATOR_BYTES:  separator_bytes      <= write_data;
        REG_SEPARATOR_LENGTH: separator_length     <= write_data[SEP_LEN_BITS-1:0];
        REG_TRIM_SPACES:      trim_trailing_spaces <= write_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos           <= '0;
      cfs           <= '0;
      fill          <= '0;
      field_counter <= '0;
      for (int i = 0; i < MAX_SEPARATOR; i++) begin
        hist[i] <= '0;
      end
    end else if (accept) begin
      if (line_end) begin
        pos           <= '0;
        cfs           <= '0;
        fill          <= '0;
        field_counter <= '0;
        for (int i = 0; i < MAX_SEPARATOR; i++) begin
          hist[i] <= '0;
        end
      end else if (match) begin
        pos           <= nxt;
        cfs           <= nxt;
        fill          <= '0;
        field_counter <= number_inc;
        for (int i = 0; i < MAX_SEPARATOR; i++) begin
          hist[i] <= nxt;
        end
      end else begin
        pos     <= nxt;
        fill    <= fill_next;
        hist[0] <= hist0_next;
        for (int i = 1; i < MAX_SEPARATOR; i++) begin
          hist[i] <= hist[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < MAX_SEPARATOR; i++) begin
        win[i] <= win_next[i];
      end
    end
  end

  `DFS_ASSERT(line_end_restarts_line, (accept && line_end) |=> (pos == '0 && fill == '0 && field_counter == '0))

endmodule

@@ hdl/dfs_queue.sv @@
// short record queue between front and back ends
`include "delimited_field_splitter_assert.svh"
module dfs_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic             rd_valid,
  output logic [WIDTH-1:0] rd_data
);
  import dfs_pkg::*;

  logic [WIDTH-1:0]            slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0]   wr_ptr;
  logic [QUEUE_PTR_BITS-1:0]   rd_ptr;
  logic [QUEUE_COUNT_BITS-1:0] count;
  logic [QUEUE_COUNT_BITS-1:0] count_next;

  assign full     = (count == QUEUE_COUNT_BITS'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];

  always_comb begin
    unique case ({push, pop})
      2'b10:   count_next = count + QUEUE_COUNT_BITS'(1);
      2'b01:   count_next = count - QUEUE_COUNT_BITS'(1);
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  `DFS_ASSERT_NEVER(no_push_when_full, push && full)
  `DFS_ASSERT_NEVER(no_pop_when_empty, pop && !rd_valid)

endmodule

@@ hdl/dfs_back.sv @@
// back end: unpacks records into words and applies the trailing-space trim
`include "delimited_field_splitter_assert.svh"
module dfs_back #(
  parameter int MAX_FIELDS    = dfs_pkg::DEF_MAX_FIELDS,
  parameter int OFFSET_BITS   = dfs_pkg::DEF_OFFSET_BITS,
  localparam int FNUM_BITS    = $clog2(MAX_FIELDS),
  localparam int REC_BITS     = 3 + 2 * (3 * OFFSET_BITS + FNUM_BITS)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  logic [REC_BITS-1:0]    q_rec,
  output logic                   pop,
  output logic                   field_valid,
  input  logic                   field_stall,
  output logic [OFFSET_BITS-1:0] field_start,
  output logic [OFFSET_BITS-1:0] field_length,
  output logic [FNUM_BITS-1:0]   field_number,
  output logic                   last_field
);
  import dfs_pkg::*;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] start;
    logic [OFFSET_BITS-1:0] stop;
    logic [OFFSET_BITS-1:0] ns_end;
    logic [FNUM_BITS-1:0]   number;
  } dfs_res_t;

  typedef struct packed {
    logic     sep_valid;
    dfs_res_t sep;
    logic     end_valid;
    dfs_res_t fin;
    logic     trim;
  } dfs_rec_t;

  dfs_rec_t               held;
  dfs_rec_t               incoming;
  logic                   pend_sep;
  logic                   pend_end;
  logic                   take;
  dfs_res_t               cur;
  logic [OFFSET_BITS-1:0] lower;
  logic [OFFSET_BITS-1:0] trimmed_end;

  assign incoming    = q_rec;
  assign field_valid = pend_sep || pend_end;
  assign take        = field_valid && !field_stall;
  assign pop         = q_valid && (!field_valid || (take && !(pend_sep && pend_end)));

  assign cur          = pend_sep ? held.sep : held.fin;
  assign lower        = (cur.ns_end < cur.stop) ? cur.ns_end : cur.stop;
  assign trimmed_end  = !held.trim ? cur.stop :
                        (lower < cur.start) ? cur.start : lower;
  assign field_start  = cur.start;
  assign field_length = trimmed_end - cur.start;
  assign field_number = cur.number;
  assign last_field   = !pend_sep;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_sep <= 1'b0;
      pend_end <= 1'b0;
    end else begin
      priority if (pop) begin
        pend_sep <= incoming.sep_valid;
        pend_end <= incoming.end_valid;
      end else if (take && pend_sep) begin
        pend_sep <= 1'b0;
      end else if (take) begin
        pend_end <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      held <= incoming;
    end
  end

  `DFS_ASSERT(second_word_follows, (take && pend_sep && pend_end) |=> (field_valid && last_field))

endmodule

@@ hdl/delimited_field_splitter.sv @@
// Delimited field splitter: takes one byte of a text line per accepted word and reports
// each field as start offset, length after optional trailing-space trim, field number and
// a last-field flag. The front end matches the separator and takes one byte per clock; it
// pushes a record into a four-entry queue for every byte that closes a field or ends the
// line, and stalls only while that queue is full. The back end hands out one word per
// clock while field_stall is low, so a byte that completes a separator on the line-end
// byte yields two words. A record passes through a queue slot and then the back-end
// hold register. Configuration is written through write_enable, register_index and
// write_data: index 0 is the separator bytes (first byte in the low bits), index 1 the
// separator length, index 2 the trim enable; other indexes are ignored.
module delimited_field_splitter #(
  parameter int MAX_SEPARATOR = dfs_pkg::DEF_MAX_SEPARATOR,
  parameter int OFFSET_BITS   = dfs_pkg::DEF_OFFSET_BITS,
  parameter int MAX_FIELDS    = dfs_pkg::DEF_MAX_FIELDS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               write_enable,
  input  logic [dfs_pkg::CFG_INDEX_BITS-1:0] register_index,
  input  logic [dfs_pkg::CFG_DATA_BITS-1:0]  write_data,
  input  logic                               byte_valid,
  output logic                               byte_stall,
  input  logic [7:0]                         data_byte,
  input  logic                               line_end,
  output logic                               field_valid,
  input  logic                               field_stall,
  output logic [OFFSET_BITS-1:0]             field_start,
  output logic [OFFSET_BITS-1:0]             field_length,
  output logic [$clog2(MAX_FIELDS)-1:0]      field_number,
  output logic                               last_field
);
  import dfs_pkg::*;

  localparam int FNUM_BITS = $clog2(MAX_FIELDS);
  localparam int REC_BITS  = 3 + 2 * (3 * OFFSET_BITS + FNUM_BITS);

  logic                queue_full;
  logic                push;
  logic [REC_BITS-1:0] push_rec;
  logic                pop;
  logic                q_valid;
  logic [REC_BITS-1:0] q_rec;

  dfs_front #(
    .MAX_SEPARATOR (MAX_SEPARATOR),
    .OFFSET_BITS   (OFFSET_BITS),
    .MAX_FIELDS    (MAX_FIELDS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .write_enable   (write_enable),
    .register_index (register_index),
    .write_data     (write_data),
    .byte_valid     (byte_valid),
    .byte_stall     (byte_stall),
    .data_byte      (data_byte),
    .line_end       (line_end),
    .queue_full     (queue_full),
    .push           (push),
    .rec            (push_rec)
  );

  dfs_queue #(
    .WIDTH (REC_BITS)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_data  (push_rec),
    .full     (queue_full),
    .pop      (pop),
    .rd_valid (q_valid),
    .rd_data  (q_rec)
  );

  dfs_back #(
    .MAX_FIELDS  (MAX_FIELDS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_rec        (q_rec),
    .pop          (pop),
    .field_valid  (field_valid),
    .field_stall  (field_stall),
    .field_start  (field_start),
    .field_length (field_length),
    .field_number (field_number),
    .last_field   (last_field)
  );

endmodule

@@ dv/delimited_field_splitter_tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the delimited field splitter: directed lines, saturation and random lines
module delimited_field_splitter_tb;
  import dfs_pkg::*;

  localparam int SEP_MAX      = DEF_MAX_SEPARATOR;
  localparam int OFS_BITS     = DEF_OFFSET_BITS;
  localparam int NUM_BITS     = $clog2(DEF_MAX_FIELDS);
  localparam int OFFSET_MAX   = (1 << OFS_BITS) - 1;
  localparam int FIELD_MAX    = DEF_MAX_FIELDS - 1;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_BYTES = 455;
  localparam int LONG_LINE    = 320;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OUT_OF_RANGE = 2'd3;

  typedef struct packed {
    logic [OFS_BITS-1:0] fstart;
    logic [OFS_BITS-1:0] flen;
    logic [NUM_BITS-1:0] fnum;
    logic                flast;
  } field_rec_t;

  logic clk = 1'b0;
  logic rst;
  logic write_enable;
  logic [CFG_INDEX_BITS-1:0] register_index;
  logic [CFG_DATA_BITS-1:0] write_data;
  logic byte_valid;
  logic byte_stall;
  logic [7:0] data_byte;
  logic line_end;
  logic field_valid;
  logic field_stall;
  logic [OFS_BITS-1:0] field_start;
  logic [OFS_BITS-1:0] field_length;
  logic [NUM_BITS-1:0] field_number;
  logic last_field;

  // predictor copy of the registers and line state
  logic [CFG_DATA_BITS-1:0] sep_bytes;
  logic [SEP_LEN_BITS-1:0] sep_len;
  logic trim_on;
  int unsigned line_pos;
  int unsigned open_start;
  int unsigned open_field;
  logic [7:0] sep_window [SEP_MAX];
  int unsigned window_fill;
  int unsigned content_end [SEP_MAX];

  field_rec_t expected_fields [$];

  int mismatch_count = 0;
  int bytes_sent = 0;
  int lines_sent = 0;
  int fields_checked = 0;
  int config_writes = 0;
  int quiet_cycles = 0;
  int hold_ask = 0;
  int hold_left = 0;
  int burst_left = 0;
  bit idle_on = 1'b1;

  delimited_field_splitter uut (
    .clk(clk),
    .rst(rst),
    .write_enable(write_enable),
    .register_index(register_index),
    .write_data(write_data),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .data_byte(data_byte),
    .line_end(line_end),
    .field_valid(field_valid),
    .field_stall(field_stall),
    .field_start(field_start),
    .field_length(field_length),
    .field_number(field_number),
    .last_field(last_field)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned eff_len(input logic [SEP_LEN_BITS-1:0] l);
    if (l == 0) return 1;
    if (l > SEP_MAX) return SEP_MAX;
    return 32'(l);
  endfunction

  function automatic void clear_line();
    int i;
    line_pos = 0;
    open_start = 0;
    open_field = 0;
    window_fill = 0;
    for (i = 0; i < SEP_MAX; i++) begin
      sep_window[i] = 8'h00;
      content_end[i] = 0;
    end
  endfunction

  function automatic void push_field(input int unsigned s, input int unsigned e,
                                     input logic lst);
    field_rec_t rec;
    rec.fstart = OFS_BITS'(s);
    rec.flen = OFS_BITS'(e - s);
    rec.fnum = NUM_BITS'(open_field);
    rec.flast = lst;
    expected_fields.push_back(rec);
  endfunction

  // works out the fields closed by one accepted byte
  function automatic void predict_fields(input logic [7:0] b, input logic eol);
    int unsigned n, nxt, prior, ends, fe;
    int i;
    bit hit;
    n = eff_len(sep_len);
    nxt = (line_pos < OFFSET_MAX) ? line_pos + 1 : OFFSET_MAX;
    for (i = SEP_MAX - 1; i > 0; i--) sep_window[i] = sep_window[i-1];
    sep_window[0] = b;
    if (window_fill < SEP_MAX) window_fill++;
    prior = content_end[n-1];
    for (i = SEP_MAX - 1; i > 0; i--) content_end[i] = content_end[i-1];
    content_end[0] = (b != SPACE_CHAR) ? nxt : content_end[1];
    hit = (window_fill >= n);
    for (i = 0; i < n; i++) begin
      if (sep_window[n-1-i] != sep_bytes[8*i +: 8]) hit = 1'b0;
    end
    if (hit) begin
      ends = (nxt >= open_start + n) ? nxt - n : open_start;
      fe = ends;
      if (trim_on) begin
        fe = prior;
        if (fe > ends) fe = ends;
        if (fe < open_start) fe = open_start;
      end
      push_field(open_start, fe, 1'b0);
      if (open_field < FIELD_MAX) open_field++;
      open_start = nxt;
      window_fill = 0;
      for (i = 0; i < SEP_MAX; i++) content_end[i] = nxt;
    end
    if (eol) begin
      fe = nxt;
      if (trim_on) begin
        fe = content_end[0];
        if (fe > nxt) fe = nxt;
        if (fe < open_start) fe = open_start;
      end
      push_field(open_start, fe, 1'b1);
      clear_line();
    end else begin
      line_pos = nxt;
    end
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // receiver side: random stall bursts plus requested long holds
  always @(posedge clk) begin
    if (hold_ask != 0) begin
      hold_left = hold_ask;
      hold_ask = 0;
    end
    if (hold_left != 0) begin
      field_stall <= 1'b1;
      hold_left--;
    end else if (burst_left != 0) begin
      field_stall <= 1'b1;
      burst_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      field_stall <= 1'b1;
      burst_left = $urandom_range(1, 12) - 1;
    end else begin
      field_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_fields
    field_rec_t want;
    if (!rst && field_valid && !field_stall) begin
      if (expected_fields.size() == 0) begin
        report_mismatch("field word with nothing expected", field_start, -1);
      end else begin
        want = expected_fields.pop_front();
        fields_checked++;
        if (field_start !== want.fstart) report_mismatch("field_start", field_start, want.fstart);
        if (field_length !== want.flen) report_mismatch("field_length", field_length, want.flen);
        if (field_number !== want.fnum) report_mismatch("field_number", field_number, want.fnum);
        if (last_field !== want.flast) report_mismatch("last_field", last_field, want.flast);
      end
    end
  end

  always @(posedge clk) begin
    if ((byte_valid && !byte_stall) || (field_valid && !field_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eol);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    data_byte <= b;
    line_end <= eol;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    predict_fields(b, eol);
    bytes_sent++;
    if (eol) lines_sent++;
  endtask

  task automatic send_line(input logic [7:0] text [$]);
    int i;
    for (i = 0; i < text.size(); i++) send_byte(text[i], i == text.size() - 1);
  endtask

  task automatic wait_drained();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (expected_fields.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
    write_enable <= 1'b1;
    register_index <= idx;
    write_data <= value;
    @(posedge clk);
    case (idx)
      REG_SEPARATOR_BYTES:  sep_bytes = value;
      REG_SEPARATOR_LENGTH: sep_len = value[SEP_LEN_BITS-1:0];
      REG_TRIM_SPACES:      trim_on = value[0];
      default: ;
    endcase
    config_writes++;
    write_enable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_default_comma();
    send_line('{8'h00, ",", 8'hFF, " ", ","});
    send_line('{","});
    wait_drained();
  endtask

  task automatic test_eight_byte_separator();
    write_reg(REG_SEPARATOR_BYTES, '1);
    write_reg(REG_SEPARATOR_LENGTH, 64'd8);
    write_reg(REG_TRIM_SPACES, 64'd1);
    // full match, then a partial match that stays in the last field
    send_line('{"x", " ", 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                8'hFF, 8'hFF, 8'hFF, " "});
    wait_drained();
  endtask

  task automatic test_length_clamp();
    write_reg(REG_SEPARATOR_BYTES, 64'd0);
    write_reg(REG_SEPARATOR_LENGTH, 64'd0);
    write_reg(REG_TRIM_SPACES, 64'd0);
    write_reg(REG_OUT_OF_RANGE, '1);
    send_line('{"a", 8'h00, "b"});
    wait_drained();
    write_reg(REG_SEPARATOR_LENGTH, '1);
    send_line('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    wait_drained();
  endtask

  task automatic test_midline_write();
    write_reg(REG_SEPARATOR_BYTES, 64'h2C);
    write_reg(REG_SEPARATOR_LENGTH, 64'd1);
    send_byte("x", 1'b0);
    send_byte(";", 1'b0);
    wait_drained();
    // window already holds the first separator byte
    write_reg(REG_SEPARATOR_BYTES, {48'd0, "q", ";"});
    write_reg(REG_SEPARATOR_LENGTH, 64'd2);
    send_byte("q", 1'b0);
    send_byte("z", 1'b1);
    wait_drained();
  endtask

  task automatic test_backpressure();
    int i;
    write_reg(REG_SEPARATOR_BYTES, 64'h2C);
    write_reg(REG_SEPARATOR_LENGTH, 64'd1);
    idle_on = 1'b0;
    hold_ask = 80;
    for (i = 0; i < 40; i++) send_byte((i % 2 == 0) ? 8'h2C : 8'h61, i % 10 == 9);
    wait_drained();
    idle_on = 1'b1;
  endtask

  task automatic test_long_line();
    int i;
    logic [7:0] b;
    write_reg(REG_SEPARATOR_BYTES, 64'h2C);
    write_reg(REG_SEPARATOR_LENGTH, 64'd1);
    write_reg(REG_TRIM_SPACES, 64'd1);
    // field numbers saturate on this line
    for (i = 0; i < LONG_LINE; i++) begin
      if (i % 8 != 7 || i == LONG_LINE - 1) b = ",";
      else b = ($urandom_range(0, 3) == 0) ? 8'h20 : 8'h78;
      send_byte(b, i == LONG_LINE - 1);
    end
    wait_drained();
  endtask

  function automatic logic [7:0] pick_sep_byte();
    case ($urandom_range(0, 6))
      0: return ",";
      1: return ";";
      2: return "|";
      3: return " ";
      4: return "a";
      5: return 8'h00;
      default: return 8'hFF;
    endcase
  endfunction

  function automatic logic [7:0] pick_text_byte();
    case ($urandom_range(0, 9))
      0, 1:    return "a";
      2, 3:    return "b";
      4, 5:    return " ";
      6, 7:    return sep_bytes[8*$urandom_range(0, eff_len(sep_len) - 1) +: 8];
      8:       return 8'($urandom_range(0, 255));
      default: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    endcase
  endfunction

  task automatic pick_random_settings();
    logic [CFG_DATA_BITS-1:0] sb;
    logic [CFG_DATA_BITS-1:0] sl;
    logic [CFG_DATA_BITS-1:0] tr;
    int i;
    for (i = 0; i < SEP_MAX; i++) sb[8*i +: 8] = pick_sep_byte();
    sl = {$urandom, $urandom};
    sl[SEP_LEN_BITS-1:0] = ($urandom_range(0, 3) == 0) ? SEP_LEN_BITS'($urandom_range(0, 15))
                                                        : SEP_LEN_BITS'($urandom_range(1, 3));
    tr = {$urandom, $urandom};
    if ($urandom_range(0, 1)) begin
      write_reg(REG_SEPARATOR_BYTES, sb);
      write_reg(REG_SEPARATOR_LENGTH, sl);
      write_reg(REG_TRIM_SPACES, tr);
    end else begin
      write_reg(REG_TRIM_SPACES, tr);
      write_reg(REG_SEPARATOR_LENGTH, sl);
      write_reg(REG_SEPARATOR_BYTES, sb);
    end
    if ($urandom_range(0, 4) == 0) write_reg(REG_OUT_OF_RANGE, {$urandom, $urandom});
  endtask

  task automatic send_random_line(inout int count);
    logic [7:0] text [$];
    int nf, f, j, k, eff;
    eff = eff_len(sep_len);
    if ($urandom_range(0, 9) == 0) begin
      // noise line over the full byte range
      k = $urandom_range(1, 20);
      for (j = 0; j < k; j++) text.push_back(8'($urandom_range(0, 255)));
    end else begin
      nf = $urandom_range(1, 5);
      for (f = 0; f < nf; f++) begin
        k = $urandom_range(0, 6);
        for (j = 0; j < k; j++) text.push_back(pick_text_byte());
        if (f < nf - 1 || $urandom_range(0, 4) == 0) begin
          k = ($urandom_range(0, 6) == 0) ? $urandom_range(0, eff - 1) : eff;
          for (j = 0; j < k; j++) text.push_back(sep_bytes[8*j +: 8]);
          if ($urandom_range(0, 9) == 0 && k > 0) text[text.size() - 1] = pick_text_byte();
        end
      end
      if (text.size() == 0) text.push_back(pick_text_byte());
    end
    count += text.size();
    send_line(text);
  endtask

  task automatic test_random_lines();
    int phase, count, target;
    count = 0;
    for (phase = 0; phase < 8; phase++) begin
      if (phase == 7) idle_on = 1'b0;
      wait_drained();
      pick_random_settings();
      target = RANDOM_BYTES * (phase + 1) / 8;
      while (count < target) send_random_line(count);
    end
    wait_drained();
  endtask

  initial begin
    rst <= 1'b1;
    write_enable <= 1'b0;
    register_index <= REG_SEPARATOR_BYTES;
    write_data <= '0;
    byte_valid <= 1'b0;
    data_byte <= 8'h00;
    line_end <= 1'b0;
    sep_bytes = RESET_SEPARATOR_BYTES;
    sep_len = RESET_SEPARATOR_LENGTH;
    trim_on = 1'b0;
    clear_line();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_comma();
    test_eight_byte_separator();
    test_length_clamp();
    test_midline_write();
    test_backpressure();
    test_long_line();
    test_random_lines();

    repeat (20) @(posedge clk);
    if (expected_fields.size() != 0)
      report_mismatch("field words never delivered", 0, expected_fields.size());
    $display("covered %0d lines, %0d bytes, %0d field words checked", lines_sent, bytes_sent,
             fields_checked);
    $display("with %0d register writes, field number saturation, long output holds",
             config_writes);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
